// ----- design/pgda_pkg.sv -----
package pgda_pkg;

    localparam int PARTICLE_COUNT = 1024;

    localparam int IN_W  = 592;
    localparam int OUT_W = 192;

    localparam logic [31:0] RST_DRAG_COEFF   = 32'd16777216;
    localparam logic [31:0] RST_GAS_RATIO    = 32'd4273492460;
    localparam logic [62:0] RST_CENTRAL_MASS = 63'd281474976710656;
    localparam logic [63:0] RST_SIZE_GAIN    = 64'd6027000000;
    localparam logic [9:0]  RST_FIRST_INDEX  = 10'd2;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        CFG_DRAG_COEFF   = 3'd0,
        CFG_GAS_RATIO    = 3'd1,
        CFG_CENTRAL_MASS = 3'd2,
        CFG_SIZE_GAIN    = 3'd3,
        CFG_FIRST_INDEX  = 3'd4
    } cfg_idx_t;

    // per-particle context riding along the pipe
    typedef struct packed {
        logic            nodrag;
        logic            zr;
        logic            sat;
        logic            pxn;
        logic            pyn;
        logic [2:0]      uneg;
        logic [63:0]     pxm;
        logic [63:0]     pym;
        logic [63:0]     r;
        logic [2:0][63:0] vel;
        logic [2:0][63:0] acc;
        logic [57:0]     s;
    } ctx_t;

    typedef struct packed {
        logic [65:0]  rem;
        logic [63:0]  root;
        logic [127:0] rad;
    } sq_t;

    typedef struct packed {
        logic [63:0]  rem;
        logic [127:0] q;
    } dv1_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] low;
    } dv2_t;

    typedef struct packed {
        logic [57:0] rem;
        logic [63:0] q;
        logic [63:0] low;
        logic        ovf;
        logic        nz;
    } dv3_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [29:0] y;
        logic [59:0] s;
        logic [89:0] rad;
    } cb_t;

endpackage

// ----- design/planetesimal_gas_drag_accel.sv -----
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       s_tdata: particle word
// m_       out  m_tvalid / m_tready       m_tdata: acc x,y,z; m_tuser: zero_radius
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One particle per cycle unless the output stalls. The pipe depth is set by
// the bit-serial chains: two 64-step square roots, a 126-step divide for the
// Kepler speed, and two 64-step divides (gas velocity, drag).
// rst_n clears the valid bits and loads the config registers with their reset values only.
// A stall on m_tready while a result waits freezes the whole pipe; s_tready follows it.
module planetesimal_gas_drag_accel #(
    parameter int PARTICLE_COUNT = pgda_pkg::PARTICLE_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // idx[9:0] px py vx vy vz (64 each) mass[62:0] ax ay az (64 each), zero pad
    input  logic [pgda_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // acc_out_x acc_out_y acc_out_z (64 each)
    output logic [pgda_pkg::OUT_W-1:0]   m_tdata,
    // zero_radius
    output logic                         m_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [63:0]                  cfg_data
);

    localparam int N_SQ  = 64;
    localparam int N_DV1 = 126;
    localparam int N_DV  = 64;
    localparam int N_CB  = 30;
    localparam int L_PP  = 1;
    localparam int L_SQ  = L_PP + 1;
    localparam int L_RSQ = L_SQ + 1;
    localparam int B_SQ1 = L_RSQ + 1;
    localparam int B_DV1 = B_SQ1 + N_SQ;
    localparam int B_SQ2 = B_DV1 + N_DV1;
    localparam int L_VGP = B_SQ2 + N_SQ;
    localparam int L_VG  = L_VGP + 1;
    localparam int L_GPP = L_VG + 1;
    localparam int L_GP  = L_GPP + 1;
    localparam int B_DV2 = L_GP + 1;
    localparam int L_U   = B_DV2 + N_DV;
    localparam int L_DPP = L_U + 1;
    localparam int L_DS1 = L_DPP + 1;
    localparam int L_DN  = L_DS1 + 1;
    localparam int B_DV3 = L_DN + 1;
    localparam int L_OUT = B_DV3 + N_DV;
    localparam int N_ST  = L_OUT + 1;
    localparam int L_CB  = N_CB + 1;

    function automatic logic [63:0] mul32(logic [31:0] a, logic [31:0] b);
        return {32'd0, a} * {32'd0, b};
    endfunction

    function automatic pgda_pkg::sq_t sq_step(pgda_pkg::sq_t a);
        logic [67:0] t;
        logic [67:0] trial;
        pgda_pkg::sq_t o;
        t = {a.rem, a.rad[127:126]};
        trial = {2'b00, a.root, 2'b01};
        o.rad = {a.rad[125:0], 2'b00};
        if (t >= trial)
        begin
            o.rem  = 66'(t - trial);
            o.root = {a.root[62:0], 1'b1};
        end
        else
        begin
            o.rem  = t[65:0];
            o.root = {a.root[62:0], 1'b0};
        end
        return o;
    endfunction

    function automatic pgda_pkg::dv1_t dv1_step(pgda_pkg::dv1_t a, logic b, logic [63:0] d);
        logic [64:0] t;
        pgda_pkg::dv1_t o;
        t = {a.rem, b};
        if (t >= {1'b0, d})
        begin
            o.rem = 64'(t - {1'b0, d});
            o.q   = {a.q[126:0], 1'b1};
        end
        else
        begin
            o.rem = t[63:0];
            o.q   = {a.q[126:0], 1'b0};
        end
        return o;
    endfunction

    function automatic pgda_pkg::dv2_t dv2_step(pgda_pkg::dv2_t a, logic [63:0] d);
        logic [64:0] t;
        pgda_pkg::dv2_t o;
        t = {a.rem, a.low[63]};
        o.low = {a.low[62:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            o.rem = 64'(t - {1'b0, d});
            o.q   = {a.q[62:0], 1'b1};
        end
        else
        begin
            o.rem = t[63:0];
            o.q   = {a.q[62:0], 1'b0};
        end
        return o;
    endfunction

    function automatic pgda_pkg::dv3_t dv3_step(pgda_pkg::dv3_t a, logic [57:0] d);
        logic [58:0] t;
        pgda_pkg::dv3_t o;
        t = {a.rem, a.low[63]};
        o.low = {a.low[62:0], 1'b0};
        o.ovf = a.ovf;
        o.nz  = a.nz;
        if (t >= {1'b0, d})
        begin
            o.rem = 58'(t - {1'b0, d});
            o.q   = {a.q[62:0], 1'b1};
        end
        else
        begin
            o.rem = t[57:0];
            o.q   = {a.q[62:0], 1'b0};
        end
        return o;
    endfunction

    // cube root digit step, tracks y^2 so no multiply is needed
    function automatic pgda_pkg::cb_t cb_step(pgda_pkg::cb_t a);
        logic [63:0] t;
        logic [63:0] b;
        pgda_pkg::cb_t o;
        t = {a.rem[60:0], a.rad[89:87]};
        b = 64'({a.s, 3'b000}) + 64'({a.s, 2'b00}) + 64'({a.y, 2'b00})
            + 64'({a.y, 1'b0}) + 64'd1;
        o.rad = {a.rad[86:0], 3'b000};
        if (t >= b)
        begin
            o.rem = t - b;
            o.y   = {a.y[28:0], 1'b1};
            o.s   = {a.s[57:0], 2'b00} + 60'({a.y, 2'b00}) + 60'd1;
        end
        else
        begin
            o.rem = t;
            o.y   = {a.y[28:0], 1'b0};
            o.s   = {a.s[57:0], 2'b00};
        end
        return o;
    endfunction

    function automatic logic [63:0] sat_apply(logic [63:0] acc, logic sub, logic [63:0] d);
        logic [65:0] a;
        logic [65:0] dd;
        logic [65:0] r;
        a  = {{2{acc[63]}}, acc};
        dd = {2'b00, d};
        r  = sub ? a - dd : a + dd;
        if (r[65])
            return (r[65:63] != 3'b111) ? pgda_pkg::SMIN : r[63:0];
        return (r[65:63] != 3'b000) ? pgda_pkg::SMAX : r[63:0];
    endfunction

    // config
    logic [31:0] drag_reg;
    logic [31:0] ratio_reg;
    logic [62:0] cm_reg;
    logic [63:0] gain_reg;
    logic [9:0]  first_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_reg  <= pgda_pkg::RST_DRAG_COEFF;
            ratio_reg <= pgda_pkg::RST_GAS_RATIO;
            cm_reg    <= pgda_pkg::RST_CENTRAL_MASS;
            gain_reg  <= pgda_pkg::RST_SIZE_GAIN;
            first_reg <= pgda_pkg::RST_FIRST_INDEX;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pgda_pkg::CFG_DRAG_COEFF:   drag_reg  <= cfg_data[31:0];
                pgda_pkg::CFG_GAS_RATIO:    ratio_reg <= cfg_data[31:0];
                pgda_pkg::CFG_CENTRAL_MASS: cm_reg    <= cfg_data[62:0];
                pgda_pkg::CFG_SIZE_GAIN:    gain_reg  <= cfg_data;
                pgda_pkg::CFG_FIRST_INDEX:  first_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Cd*K: partial products in ckp_reg, summed into ck_reg
    logic [63:0] ckp_reg [2];
    logic [95:0] ck_reg;

    always_ff @(posedge clk)
    begin
        ckp_reg[0] <= mul32(drag_reg, gain_reg[31:0]);
        ckp_reg[1] <= mul32(drag_reg, gain_reg[63:32]);
        ck_reg     <= 96'(ckp_reg[0]) + {ckp_reg[1], 32'd0};
    end

    // pipe control
    logic            adv;
    logic [N_ST-1:0] vld_reg;

    assign adv      = !vld_reg[N_ST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[N_ST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[N_ST-2:0], s_tvalid};
    end

    // context line
    pgda_pkg::ctx_t ctx_reg  [L_OUT];
    pgda_pkg::ctx_t ctx_next [L_OUT];
    logic [62:0]    mass0_reg;

    logic [63:0] in_px;
    logic [63:0] in_py;
    logic [9:0]  in_idx;

    assign in_idx = s_tdata[9:0];
    assign in_px  = s_tdata[73:10];
    assign in_py  = s_tdata[137:74];

    always_comb
    begin
        ctx_next[0].nodrag = (in_idx < first_reg)
                           || ({7'd0, in_idx} >= 17'(PARTICLE_COUNT));
        ctx_next[0].zr     = 1'b0;
        ctx_next[0].sat    = 1'b0;
        ctx_next[0].pxn    = in_px[63];
        ctx_next[0].pyn    = in_py[63];
        ctx_next[0].uneg   = 3'b000;
        ctx_next[0].pxm    = in_px[63] ? 64'(-in_px) : in_px;
        ctx_next[0].pym    = in_py[63] ? 64'(-in_py) : in_py;
        ctx_next[0].r      = 64'd0;
        ctx_next[0].vel[0] = s_tdata[201:138];
        ctx_next[0].vel[1] = s_tdata[265:202];
        ctx_next[0].vel[2] = s_tdata[329:266];
        ctx_next[0].acc[0] = s_tdata[456:393];
        ctx_next[0].acc[1] = s_tdata[520:457];
        ctx_next[0].acc[2] = s_tdata[584:521];
        ctx_next[0].s      = 58'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            mass0_reg <= s_tdata[392:330];
    end

    // unit registers
    logic [63:0]    pp_reg [6];
    logic [127:0]   sq_reg [2];
    logic [127:0]   rsq_reg;
    pgda_pkg::sq_t  sq1_reg [N_SQ];
    pgda_pkg::dv1_t dv1_reg [N_DV1];
    pgda_pkg::sq_t  sq2_reg [N_SQ];
    logic [63:0]    vgp_reg [2];
    logic [63:0]    vg_reg;
    logic [63:0]    gpp_reg [2][4];
    logic [127:0]   gp_reg [2];
    pgda_pkg::dv2_t dv2_reg [2][N_DV];
    logic [63:0]    umag_reg [3];
    logic [63:0]    dpp_reg [3][2][3];
    logic [127:0]   row_reg [3][2];
    pgda_pkg::dv3_t dn_reg [3];
    pgda_pkg::dv3_t dv3_reg [3][N_DV];
    pgda_pkg::cb_t  cb_reg [N_CB];
    logic [63:0]    out_reg [3];
    logic           zr_out_reg;

    logic        sat_now;
    logic [63:0] r_fin;
    logic [65:0] u_sum [3];
    logic [2:0]  u_neg;
    logic [63:0] vk;

    assign r_fin   = sq1_reg[N_SQ-1].root;
    assign sat_now = (r_fin[63:33] == 31'd0) && (cm_reg >= {r_fin[32:0], 30'd0});

    genvar k, i, j, h, g;

    generate
        for (k = 1; k < L_OUT; k++)
        begin : g_ctx
            always_comb
            begin : p_ctx
                pgda_pkg::ctx_t c;
                c = ctx_reg[k-1];
                if (k == B_SQ1)
                    c.zr = (rsq_reg == 128'd0);
                if (k == L_CB)
                    c.s = cb_reg[N_CB-1].s[57:0];
                if (k == B_DV1)
                begin
                    c.r   = r_fin;
                    c.sat = sat_now;
                end
                if (k == L_U)
                    c.uneg = u_neg;
                ctx_next[k] = c;
            end
        end
        for (k = 0; k < L_OUT; k++)
        begin : g_ctx_reg
            always_ff @(posedge clk)
            begin
                if (adv)
                    ctx_reg[k] <= ctx_next[k];
            end
        end
    endgenerate

    // radius squared
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg[0] <= mul32(ctx_reg[0].pxm[63:32], ctx_reg[0].pxm[63:32]);
            pp_reg[1] <= mul32(ctx_reg[0].pxm[63:32], ctx_reg[0].pxm[31:0]);
            pp_reg[2] <= mul32(ctx_reg[0].pxm[31:0], ctx_reg[0].pxm[31:0]);
            pp_reg[3] <= mul32(ctx_reg[0].pym[63:32], ctx_reg[0].pym[63:32]);
            pp_reg[4] <= mul32(ctx_reg[0].pym[63:32], ctx_reg[0].pym[31:0]);
            pp_reg[5] <= mul32(ctx_reg[0].pym[31:0], ctx_reg[0].pym[31:0]);
            sq_reg[0] <= {pp_reg[0], 64'd0} + (128'(pp_reg[1]) << 33) + 128'(pp_reg[2]);
            sq_reg[1] <= {pp_reg[3], 64'd0} + (128'(pp_reg[4]) << 33) + 128'(pp_reg[5]);
            rsq_reg   <= sq_reg[0] + sq_reg[1];
        end
    end

    generate
        // r = isqrt(rsq)
        for (i = 0; i < N_SQ; i++)
        begin : g_sq1
            pgda_pkg::sq_t a;
            if (i == 0)
            begin : g_first
                assign a = '{rem: 66'd0, root: 64'd0, rad: rsq_reg};
            end
            else
            begin : g_rest
                assign a = sq1_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    sq1_reg[i] <= sq_step(a);
            end
        end

        // central_mass * 2^96 / r
        for (i = 0; i < N_DV1; i++)
        begin : g_dv1
            localparam int NB = N_DV1 - 1 - i;
            pgda_pkg::dv1_t a;
            logic [63:0]    d;
            logic           b;
            if (i == 0)
            begin : g_first
                assign a = '{rem: {31'd0, cm_reg[62:30]}, q: 128'd0};
                assign d = r_fin;
            end
            else
            begin : g_rest
                assign a = dv1_reg[i-1];
                assign d = ctx_reg[B_DV1+i-1].r;
            end
            if (NB >= 96)
            begin : g_mbit
                assign b = cm_reg[NB-96];
            end
            else
            begin : g_zbit
                assign b = 1'b0;
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    dv1_reg[i] <= dv1_step(a, b, d);
            end
        end

        // Kepler speed
        for (i = 0; i < N_SQ; i++)
        begin : g_sq2
            pgda_pkg::sq_t a;
            if (i == 0)
            begin : g_first
                assign a = '{rem: 66'd0, root: 64'd0, rad: dv1_reg[N_DV1-1].q};
            end
            else
            begin : g_rest
                assign a = sq2_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    sq2_reg[i] <= sq_step(a);
            end
        end

        // mass cube root, in parallel with the radius chain
        for (i = 0; i < N_CB; i++)
        begin : g_cb
            pgda_pkg::cb_t a;
            if (i == 0)
            begin : g_first
                assign a = '{rem: 64'd0, y: 30'd0, s: 60'd0,
                             rad: {3'b000, mass0_reg, 24'd0}};
            end
            else
            begin : g_rest
                assign a = cb_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    cb_reg[i] <= cb_step(a);
            end
        end
    endgenerate

    assign vk = ctx_reg[L_VGP-1].sat ? pgda_pkg::SMAX : sq2_reg[N_SQ-1].root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vgp_reg[0] <= mul32(vk[31:0], ratio_reg);
            vgp_reg[1] <= mul32(vk[63:32], ratio_reg);
            vg_reg     <= vgp_reg[1] + {32'd0, vgp_reg[0][63:32]};
        end
    end

    // gas velocity: x part from |y|, y part from |x|
    generate
        for (h = 0; h < 2; h++)
        begin : g_gas
            logic [63:0] m;
            assign m = (h == 0) ? ctx_reg[L_GPP-1].pym : ctx_reg[L_GPP-1].pxm;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    gpp_reg[h][0] <= mul32(vg_reg[31:0], m[31:0]);
                    gpp_reg[h][1] <= mul32(vg_reg[31:0], m[63:32]);
                    gpp_reg[h][2] <= mul32(vg_reg[63:32], m[31:0]);
                    gpp_reg[h][3] <= mul32(vg_reg[63:32], m[63:32]);
                    gp_reg[h] <= 128'(gpp_reg[h][0]) + (128'(gpp_reg[h][1]) << 32)
                               + (128'(gpp_reg[h][2]) << 32) + {gpp_reg[h][3], 64'd0};
                end
            end
            for (i = 0; i < N_DV; i++)
            begin : g_dv2
                pgda_pkg::dv2_t a;
                if (i == 0)
                begin : g_first
                    assign a = '{rem: gp_reg[h][127:64], q: 64'd0, low: gp_reg[h][63:0]};
                end
                else
                begin : g_rest
                    assign a = dv2_reg[h][i-1];
                end
                always_ff @(posedge clk)
                begin
                    if (adv)
                        dv2_reg[h][i] <= dv2_step(a, ctx_reg[B_DV2+i-1].r);
                end
            end
        end
    endgenerate

    // relative velocity
    always_comb
    begin : p_u
        logic [65:0] vx;
        logic [65:0] vy;
        logic [65:0] qx;
        logic [65:0] qy;
        vx = {{2{ctx_reg[L_U-1].vel[0][63]}}, ctx_reg[L_U-1].vel[0]};
        vy = {{2{ctx_reg[L_U-1].vel[1][63]}}, ctx_reg[L_U-1].vel[1]};
        qx = {2'b00, dv2_reg[0][N_DV-1].q};
        qy = {2'b00, dv2_reg[1][N_DV-1].q};
        u_sum[0] = ctx_reg[L_U-1].pyn ? vx - qx : vx + qx;
        u_sum[1] = ctx_reg[L_U-1].pxn ? vy + qy : vy - qy;
        u_sum[2] = {{2{ctx_reg[L_U-1].vel[2][63]}}, ctx_reg[L_U-1].vel[2]};
        u_neg    = {u_sum[2][65], u_sum[1][65], u_sum[0][65]};
    end

    // drag per axis
    generate
        for (j = 0; j < 3; j++)
        begin : g_drag
            logic [159:0] t;
            logic [119:0] n;
            logic [63:0]  d;
            assign t = 160'(row_reg[j][0]) + {row_reg[j][1], 32'd0};
            assign n = t[159:40];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    umag_reg[j] <= u_sum[j][65] ? 64'(-u_sum[j]) : u_sum[j][63:0];
                    dn_reg[j].rem <= {2'b00, n[119:64]};
                    dn_reg[j].q   <= 64'd0;
                    dn_reg[j].low <= n[63:0];
                    dn_reg[j].ovf <= ({2'b00, n[119:64]} >= ctx_reg[L_DN-1].s)
                                     && (n != 120'd0);
                    dn_reg[j].nz  <= (n != 120'd0);
                end
            end

            for (h = 0; h < 2; h++)
            begin : g_row
                for (g = 0; g < 3; g++)
                begin : g_pp
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                            dpp_reg[j][h][g] <= mul32(ck_reg[32*g +: 32],
                                                      umag_reg[j][32*h +: 32]);
                    end
                end
                always_ff @(posedge clk)
                begin
                    if (adv)
                        row_reg[j][h] <= 128'(dpp_reg[j][h][0])
                                       + (128'(dpp_reg[j][h][1]) << 32)
                                       + {dpp_reg[j][h][2], 64'd0};
                end
            end

            for (i = 0; i < N_DV; i++)
            begin : g_dv3
                pgda_pkg::dv3_t a;
                if (i == 0)
                begin : g_first
                    assign a = dn_reg[j];
                end
                else
                begin : g_rest
                    assign a = dv3_reg[j][i-1];
                end
                always_ff @(posedge clk)
                begin
                    if (adv)
                        dv3_reg[j][i] <= dv3_step(a, ctx_reg[B_DV3+i-1].s);
                end
            end

            assign d = !dv3_reg[j][N_DV-1].nz ? 64'd0
                     : dv3_reg[j][N_DV-1].ovf ? '1 : dv3_reg[j][N_DV-1].q;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (ctx_reg[L_OUT-1].nodrag || ctx_reg[L_OUT-1].zr)
                        out_reg[j] <= ctx_reg[L_OUT-1].acc[j];
                    else
                        out_reg[j] <= sat_apply(ctx_reg[L_OUT-1].acc[j],
                                                !ctx_reg[L_OUT-1].uneg[j], d);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
            zr_out_reg <= !ctx_reg[L_OUT-1].nodrag && ctx_reg[L_OUT-1].zr;
    end

    assign m_tdata = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser = zr_out_reg;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    typedef logic bool_t;

    typedef struct {
        logic [9:0]  idx;
        logic [63:0] px, py, vx, vy, vz;
        logic [62:0] mass;
        logic [63:0] ax, ay, az;
    } particle_t;

    typedef struct {
        logic [63:0] ax, ay, az;
        logic        zr;
    } accel_t;

    typedef struct {
        particle_t p;
        logic      typed;
        accel_t    want;
    } row_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
    logic [pgda_pkg::IN_W-1:0]  s_tdata;
    logic [pgda_pkg::OUT_W-1:0] m_tdata;
    logic cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    planetesimal_gas_drag_accel dut (.*);

    // local copy of the configuration
    logic [31:0] cd_q, ratio_q;
    logic [62:0] mstar_q;
    logic [63:0] gain_q;
    logic [9:0]  first_q;

    accel_t accel_due[$];
    int     errs, n_sent, n_got, n_drag, n_zr, idle_cnt;
    bool_t  quiet;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] root64(logic [127:0] n);
        logic [63:0]  res, c;
        logic [127:0] sq;
        res = 0;
        for (int b = 63; b >= 0; b--)
        begin
            c  = res | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= n)
                res = c;
        end
        return res;
    endfunction

    function automatic logic [29:0] cube_root(logic [127:0] n);
        logic [29:0]  res, c;
        logic [127:0] cu;
        res = 0;
        for (int b = 29; b >= 0; b--)
        begin
            c  = res | (30'd1 << b);
            cu = 128'(c) * 128'(c) * 128'(c);
            if (cu <= n)
                res = c;
        end
        return res;
    endfunction

    function automatic logic [63:0] mag64(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [127:0] gas_vel(logic [63:0] vg, logic [63:0] m, logic neg,
                                             logic [63:0] r);
        logic [127:0] q;
        q = (128'(vg) * 128'(m)) / 128'(r);
        q = {64'd0, q[63:0]};
        return neg ? 128'd0 - q : q;
    endfunction

    function automatic logic [63:0] drag_accel(logic [63:0] acc, logic [127:0] u,
                                               logic [95:0] ck, logic [59:0] s);
        logic [127:0] un;
        logic [63:0]  umag, d;
        logic [191:0] n, q;
        logic signed [129:0] a, res;
        un   = 128'd0 - u;
        umag = u[127] ? un[63:0] : u[63:0];
        n    = (192'(ck) * 192'(umag)) >> 40;
        if (s == 0)
            d = (n != 0) ? '1 : 64'd0;
        else
        begin
            q = n / 192'(s);
            d = (q[191:64] != 0) ? '1 : q[63:0];
        end
        a   = {{66{acc[63]}}, acc};
        res = u[127] ? a + $signed({66'd0, d}) : a - $signed({66'd0, d});
        if (res > $signed({{66{1'b0}}, pgda_pkg::SMAX}))
            return pgda_pkg::SMAX;
        if (res < $signed({{66{1'b1}}, pgda_pkg::SMIN}))
            return pgda_pkg::SMIN;
        return res[63:0];
    endfunction

    function automatic accel_t predict_accel(particle_t p);
        accel_t       o;
        logic [127:0] rsq, ux, uy, uz;
        logic [63:0]  r, vk, vg;
        logic [191:0] kq;
        logic [95:0]  vgw, ck;
        logic [29:0]  cm;
        logic [59:0]  s;
        o = '{p.ax, p.ay, p.az, 1'b0};
        if (p.idx < first_q || 17'(p.idx) >= 17'(pgda_pkg::PARTICLE_COUNT))
            return o;
        rsq = 128'(mag64(p.px)) * 128'(mag64(p.px)) + 128'(mag64(p.py)) * 128'(mag64(p.py));
        if (rsq == 0)
        begin
            o.zr = 1'b1;
            return o;
        end
        r = root64(rsq);
        if (r < (64'd1 << 33) && 128'(mstar_q) >= (128'(r) << 30))
            vk = pgda_pkg::SMAX;
        else
        begin
            kq = (192'(mstar_q) << 96) / 192'(r);
            vk = root64(kq[127:0]);
        end
        vgw = 96'(vk) * 96'(ratio_q);
        vg  = vgw[95:32];
        ux  = {{64{p.vx[63]}}, p.vx} - gas_vel(vg, mag64(p.py), !p.py[63], r);
        uy  = {{64{p.vy[63]}}, p.vy} - gas_vel(vg, mag64(p.px), p.px[63], r);
        uz  = {{64{p.vz[63]}}, p.vz};
        cm  = cube_root(128'(p.mass) << 24);
        s   = 60'(cm) * 60'(cm);
        ck  = 96'(cd_q) * 96'(gain_q);
        o.ax = drag_accel(p.ax, ux, ck, s);
        o.ay = drag_accel(p.ay, uy, ck, s);
        o.az = drag_accel(p.az, uz, ck, s);
        return o;
    endfunction

    task automatic write_reg(pgda_pkg::cfg_idx_t i, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= i;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (i)
            pgda_pkg::CFG_DRAG_COEFF:   cd_q    = v[31:0];
            pgda_pkg::CFG_GAS_RATIO:    ratio_q = v[31:0];
            pgda_pkg::CFG_CENTRAL_MASS: mstar_q = v[62:0];
            pgda_pkg::CFG_SIZE_GAIN:    gain_q  = v;
            pgda_pkg::CFG_FIRST_INDEX:  first_q = v[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] cd, logic [31:0] ra, logic [62:0] ms,
                              logic [63:0] kg, logic [9:0] fi);
        write_reg(pgda_pkg::CFG_DRAG_COEFF, 64'(cd));
        write_reg(pgda_pkg::CFG_GAS_RATIO, 64'(ra));
        write_reg(pgda_pkg::CFG_CENTRAL_MASS, 64'(ms));
        write_reg(pgda_pkg::CFG_SIZE_GAIN, kg);
        write_reg(pgda_pkg::CFG_FIRST_INDEX, 64'(fi));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_particle(particle_t p, logic typed, accel_t want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, p.az, p.ay, p.ax, p.mass, p.vz, p.vy, p.vx, p.py, p.px, p.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accel_due.push_back(typed ? want : predict_accel(p));
        n_sent++;
        if (p.idx >= first_q)
            n_drag++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (accel_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rnd_q(int lo, int hi);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return $urandom_range(0, 3) == 0 ? v : 64'($signed(v) >>> $urandom_range(lo, hi));
    endfunction

    function automatic particle_t rnd_particle();
        particle_t p;
        p.idx  = ($urandom_range(0, 9) != 0 && first_q != 10'h3FF) ?
                 10'($urandom_range(first_q, 1023)) : 10'($urandom);
        p.px   = rnd_q(1, 40);
        p.py   = rnd_q(1, 40);
        if ($urandom_range(0, 30) == 0)
        begin
            p.px = 0;
            p.py = 0;
        end
        p.vx   = rnd_q(1, 62);
        p.vy   = rnd_q(1, 62);
        p.vz   = rnd_q(1, 62);
        p.mass = ($urandom_range(0, 19) == 0) ? 63'd0 :
                 63'({$urandom, $urandom} >> $urandom_range(1, 63));
        p.ax   = ($urandom_range(0, 9) == 0) ?
                 pgda_pkg::SMAX - 64'($urandom_range(0, 3)) : rnd_q(1, 62);
        p.ay   = ($urandom_range(0, 9) == 0) ?
                 pgda_pkg::SMIN + 64'($urandom_range(0, 3)) : rnd_q(1, 62);
        p.az   = rnd_q(1, 62);
        return p;
    endfunction

    function automatic row_t mk(logic [9:0] i, logic [63:0] x, logic [63:0] y,
                                logic [63:0] v, logic [62:0] m, logic [63:0] a,
                                logic typed, logic zr);
        row_t t;
        t.p     = '{i, x, y, v, ~v, v ^ 64'h5555_5555_5555_5555, m, a, ~a, a + 64'd1};
        t.typed = typed;
        t.want  = '{a, ~a, a + 64'd1, zr};
        return t;
    endfunction

    // accepted results, checked in order
    always @(posedge clk)
    begin
        accel_t w;
        logic   acc_s, acc_m;
        acc_s = s_tvalid && s_tready;
        acc_m = m_tvalid && m_tready;
        if (rst_n && acc_m)
        begin
            n_got++;
            if (accel_due.size() == 0)
            begin
                $error("result word with nothing expected");
                errs++;
            end
            else
            begin
                w = accel_due.pop_front();
                if (m_tdata[63:0] !== w.ax)
                begin
                    $error("acc_out_x exp %h got %h", w.ax, m_tdata[63:0]);
                    errs++;
                end
                if (m_tdata[127:64] !== w.ay)
                begin
                    $error("acc_out_y exp %h got %h", w.ay, m_tdata[127:64]);
                    errs++;
                end
                if (m_tdata[191:128] !== w.az)
                begin
                    $error("acc_out_z exp %h got %h", w.az, m_tdata[191:128]);
                    errs++;
                end
                if (m_tuser !== w.zr)
                begin
                    $error("zero_radius exp %b got %b", w.zr, m_tuser);
                    errs++;
                end
                if (w.zr)
                    n_zr++;
            end
        end
        if (acc_s || acc_m || (cfg_valid && cfg_ready) || !rst_n)
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt > 20000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        row_t rows[$];
        particle_t p;
        accel_t none;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = pgda_pkg::CFG_DRAG_COEFF;
        cfg_data  = '0;
        rst_n     = 1'b0;
        errs = 0; n_sent = 0; n_got = 0; n_drag = 0; n_zr = 0; idle_cnt = 0;
        quiet = 1'b0;
        none  = '{0, 0, 0, 0};
        cd_q    = pgda_pkg::RST_DRAG_COEFF;
        ratio_q = pgda_pkg::RST_GAS_RATIO;
        mstar_q = pgda_pkg::RST_CENTRAL_MASS;
        gain_q  = pgda_pkg::RST_SIZE_GAIN;
        first_q = pgda_pkg::RST_FIRST_INDEX;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then edge cases
        rows.push_back(mk(10'd0, pgda_pkg::SMAX, pgda_pkg::SMIN, pgda_pkg::SMAX,
                          63'h7FFF_FFFF_FFFF_FFFF, pgda_pkg::SMAX, 1, 0));
        rows.push_back(mk(10'd1, 64'd1, 64'd1, pgda_pkg::SMIN, 63'd1, pgda_pkg::SMIN, 1, 0));
        rows.push_back(mk(10'd2, 64'd0, 64'd0, pgda_pkg::SMAX, 63'd5, pgda_pkg::SMIN, 1, 1));
        rows.push_back(mk(10'h3FF, 64'd0, 64'd0, pgda_pkg::SMIN, 63'h7FFF_FFFF_FFFF_FFFF,
                          pgda_pkg::SMAX, 1, 1));
        rows.push_back(mk(10'd5, 64'h0001_0000_0000_0000, 64'd0, 64'd0,
                          63'h0000_0001_0000_0000, 64'd0, 0, 0));
        rows.push_back(mk(10'd6, 64'h0000_B504_F333_F9DE, 64'hFFFF_4AFB_0CCC_0622,
                          64'h0000_0100_0000_0000, 63'h0000_0000_1000_0000, 64'd7, 0, 0));
        rows.push_back(mk(10'd7, pgda_pkg::SMIN, pgda_pkg::SMAX, pgda_pkg::SMIN,
                          63'h7FFF_FFFF_FFFF_FFFF, pgda_pkg::SMAX, 0, 0));
        rows.push_back(mk(10'd8, pgda_pkg::SMAX, pgda_pkg::SMIN, pgda_pkg::SMAX, 63'd1,
                          pgda_pkg::SMIN, 0, 0));
        rows.push_back(mk(10'd9, 64'd1, 64'd0, 64'd3, 63'd100, 64'd0, 0, 0));
        rows.push_back(mk(10'd10, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 63'd0,
                          pgda_pkg::SMAX, 0, 0));
        rows.push_back(mk(10'd11, 64'd0, 64'd1, pgda_pkg::SMAX, 63'd0, pgda_pkg::SMIN, 0, 0));
        rows.push_back(mk(10'h3FF, '1, '1, '1, '1, '1, 0, 0));
        rows.push_back(mk(10'd2, 64'h0002_0000_0000_0000, 64'h0003_0000_0000_0000,
                          64'hFFFF_FFF0_0000_0000, 63'h0000_0000_0000_1000,
                          pgda_pkg::SMIN, 0, 0));
        foreach (rows[k])
            send_particle(rows[k].p, rows[k].typed, rows[k].want);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(0, 0, 0, 0, 0);
                1: set_config('1, '1, '1, '1, '1);
                2: set_config(32'h0100_0000, 32'hFEB8_51EC, 63'h0001_0000_0000_0000,
                              {$urandom, $urandom}, 10'd0);
                3: set_config($urandom, $urandom, 63'({$urandom, $urandom} >> 8),
                              {$urandom, $urandom}, 10'($urandom_range(0, 20)));
                4: set_config($urandom, '1, 63'($urandom), {$urandom, $urandom} >> 16, 10'd1);
                default: set_config(pgda_pkg::RST_DRAG_COEFF, pgda_pkg::RST_GAS_RATIO,
                                    pgda_pkg::RST_CENTRAL_MASS, pgda_pkg::RST_SIZE_GAIN,
                                    10'd3);
            endcase
            quiet = (ph == 5);
            repeat (ph == 1 ? 100 : 210)
            begin
                p = rnd_particle();
                send_particle(p, 1'b0, none);
            end
            drain();
        end

        repeat (400) @(posedge clk);
        $display("Sent %0d particles over 7 register settings, %0d eligible for drag,",
                 n_sent, n_drag);
        $display("%0d results checked, %0d with zero radius", n_got, n_zr);
        if (errs == 0 && accel_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
